// ===== rtl/deque_with_lazy_key_removal_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the deque with lazy key removal
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_LAZY_KEY_REMOVAL_ASSERT_SVH
`define DEQUE_WITH_LAZY_KEY_REMOVAL_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define DLKR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DLKR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DLKR_ASSERT_NOW(label, ante, cons, msg)
`define DLKR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/dlkr_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque with lazy key removal: shared definitions
// Operation codes, result status codes and control structs.
// ----------------------------------------------------------------------------
package dlkr_pkg;

    // Operation carried by an input request.
    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_REMOVE     = 2'd2,
        KIND_POP        = 2'd3
    } t_kind;

    // Result status codes.
    localparam int STATUS_BITS = 3;
    localparam logic [STATUS_BITS-1:0] ST_DONE  = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_LIVE  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_STALE = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 3'd4;

    // Pointer unit commands; inserts and pop are already qualified by occupancy.
    typedef struct packed {
        logic ins_front;
        logic ins_back;
        logic pop;
        logic advance;
    } t_ptr_cmd;

    // Ring occupancy flags.
    typedef struct packed {
        logic empty;
        logic full;
    } t_occ;

endpackage

// ===== rtl/deque_with_lazy_key_removal.sv =====
// A push, remove or pop-on-empty result is loaded into the output register when the request
// is accepted, or parked while the output is busy; a pop of a non-empty ring reads the ring
// in S_RING, then the key table in S_KEY at the address the ring returns, and loads its result.
// No new request is taken while a pop is in progress or while a result is parked.
// Reset is synchronous and active low; it clears pointers, count, sequence and handshake
// state at once, and the ring and key table memories are not cleared.
// ----------------------------------------------------------------------------
// Deque with lazy key removal
// Ring of stamped keys in one RAM, latest stamp per key in a second RAM; pops
// check the entry stamp against the key table to tell live from stale.
// ----------------------------------------------------------------------------
`include "deque_with_lazy_key_removal_assert.svh"

module deque_with_lazy_key_removal
    import dlkr_pkg::*;
#(
    parameter int KEY_BITS    = 10,
    parameter int QUEUE_DEPTH = 1024,
    parameter int STAMP_BITS  = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_kind,
    input  logic [KEY_BITS-1:0]    i_key,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [KEY_BITS-1:0]    o_value
);

    localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int RING_WIDTH = STAMP_BITS + KEY_BITS;
    localparam int KT_WIDTH   = STAMP_BITS + 1;
    localparam int KT_DEPTH   = 2 ** KEY_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RING,
        S_KEY,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic                   r_out_valid, n_out_valid;
    logic [STATUS_BITS-1:0] r_out_status, n_out_status;
    logic [KEY_BITS-1:0]    r_out_value, n_out_value;
    logic [STATUS_BITS-1:0] r_res_status, n_res_status;
    logic [KEY_BITS-1:0]    r_res_value, n_res_value;

    t_kind                  kind;
    logic                   in_acc;
    logic                   out_free;
    logic                   is_push;
    logic                   do_push;
    logic                   do_pop;
    logic                   do_remove;
    logic [STATUS_BITS-1:0] acc_status;
    logic                   live;
    logic                   res_load;
    logic [STATUS_BITS-1:0] res_status;
    logic [KEY_BITS-1:0]    res_value;
    logic                   no_pop_out;

    t_ptr_cmd              ptr_cmd;
    t_occ                  occ;
    logic [PTR_BITS-1:0]   ring_addr;
    logic [STAMP_BITS-1:0] stamp;

    logic [RING_WIDTH-1:0] ring_rdata;
    logic [KEY_BITS-1:0]   ring_key;
    logic [STAMP_BITS-1:0] ring_stamp;
    logic                  kt_we;
    logic [KEY_BITS-1:0]   kt_addr;
    logic [KT_WIDTH-1:0]   kt_wdata;
    logic [KT_WIDTH-1:0]   kt_rdata;

    // Request decode, qualified by ring occupancy; no request is taken during reset.
    assign kind       = t_kind'(i_kind);
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign is_push    = (kind == KIND_PUSH_FRONT) || (kind == KIND_PUSH_BACK);
    assign do_push    = is_push && !occ.full;
    assign do_pop     = (kind == KIND_POP) && !occ.empty;
    assign do_remove  = (kind == KIND_REMOVE);

    always_comb begin
        acc_status = ST_DONE;
        if (is_push && occ.full) begin
            acc_status = ST_FULL;
        end else if ((kind == KIND_POP) && occ.empty) begin
            acc_status = ST_EMPTY;
        end
    end

    // Pointer unit commands.
    assign ptr_cmd.ins_front = in_acc && do_push && (kind == KIND_PUSH_FRONT);
    assign ptr_cmd.ins_back  = in_acc && do_push && (kind == KIND_PUSH_BACK);
    assign ptr_cmd.pop       = in_acc && do_pop;
    assign ptr_cmd.advance   = in_acc;

    dlkr_ptr #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STAMP_BITS  (STAMP_BITS)
    ) u_ptr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ptr_cmd),
        .i_sel_front (kind == KIND_POP),
        .o_occ       (occ),
        .o_ring_addr (ring_addr),
        .o_stamp     (stamp)
    );

    // Ring memory: written by a push, read at the front by a pop.
    dlkr_ram #(
        .WIDTH (RING_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc && do_push),
        .i_re    (in_acc && do_pop),
        .i_addr  (ring_addr),
        .i_wdata ({stamp, i_key}),
        .o_rdata (ring_rdata)
    );

    assign ring_key   = ring_rdata[KEY_BITS-1:0];
    assign ring_stamp = ring_rdata[RING_WIDTH-1:KEY_BITS];

    // Key table: a push stores the valid stamp, a remove clears the entry,
    // and a pop reads the entry of the key it took from the ring.
    assign kt_we    = in_acc && (do_push || do_remove);
    assign kt_addr  = (r_state == S_RING) ? ring_key : i_key;
    assign kt_wdata = do_remove ? '0 : {1'b1, stamp};

    dlkr_ram #(
        .WIDTH (KT_WIDTH),
        .DEPTH (KT_DEPTH)
    ) u_key_table (
        .i_clk   (i_clk),
        .i_we    (kt_we),
        .i_re    (r_state == S_RING),
        .i_addr  (kt_addr),
        .i_wdata (kt_wdata),
        .o_rdata (kt_rdata)
    );

    // The popped entry is live when its key still holds the same valid stamp.
    assign live = kt_rdata[STAMP_BITS] && (kt_rdata[STAMP_BITS-1:0] == ring_stamp);

    // Result source: immediate for requests that need no read, else the pop check.
    always_comb begin
        res_load   = 1'b0;
        res_status = acc_status;
        res_value  = '0;
        if (r_state == S_KEY) begin
            res_load   = 1'b1;
            res_status = live ? ST_LIVE : ST_STALE;
            res_value  = ring_key;
        end else if (in_acc && !do_pop) begin
            res_load = 1'b1;
        end
    end

    // Sequencer next state and output register loading.
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc && do_pop) begin
                    n_state = S_RING;
                end
            end
            S_RING: begin
                n_state = S_KEY;
            end
            S_KEY: begin
                n_state = S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // A new result goes straight out when the output is free, else it is parked.
        if (res_load) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = res_status;
                n_out_value  = res_value;
            end else begin
                n_res_status = res_status;
                n_res_value  = res_value;
                n_state      = S_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value     = r_out_value;

    // A result on the output that carries no popped entry.
    assign no_pop_out = o_out_valid && (o_status != ST_LIVE) && (o_status != ST_STALE);

    // Checks on sequencing and result formatting.
    `DLKR_ASSERT_NEXT(a_pop_starts_read, in_acc && do_pop, r_state == S_RING, "ring read missed")
    `DLKR_ASSERT_NOW(a_park_needs_busy_out, r_state == S_EMIT, r_out_valid, "parked while idle")
    `DLKR_ASSERT_NOW(a_value_zero_unless_pop, no_pop_out, o_value == '0, "value set without pop")

endmodule

// ===== rtl/dlkr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read per cycle at the shared address; read data registered and held between reads.
// ----------------------------------------------------------------------------
module dlkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage array with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dlkr_ptr.sv =====
// ----------------------------------------------------------------------------
// Ring pointer unit
// Holds the front pointer, entry count and sequence counter, and forms the
// ring slot address for the current request.
// ----------------------------------------------------------------------------
module dlkr_ptr
    import dlkr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 1024,
    parameter int STAMP_BITS  = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_ptr_cmd                       i_cmd,
    input  logic                           i_sel_front,
    output t_occ                           o_occ,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_ring_addr,
    output logic [STAMP_BITS-1:0]          o_stamp
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_SLOT  = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [PTR_BITS:0]   DEPTH_WIDE = (PTR_BITS + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_BITS-1:0] DEPTH_CNT  = CNT_BITS'(QUEUE_DEPTH);

    logic [PTR_BITS-1:0]   r_front, n_front;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [STAMP_BITS-1:0] r_seq, n_seq;

    logic [PTR_BITS-1:0] front_dec;
    logic [PTR_BITS-1:0] front_inc;
    logic [PTR_BITS:0]   back_sum;
    logic [PTR_BITS:0]   back_wrap;

    // Neighbor slots of the front, wrapping at the ring depth.
    assign front_dec = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
    assign front_inc = (r_front == LAST_SLOT) ? '0 : r_front + 1'b1;

    // Back slot is front plus count, reduced once since the sum stays below twice the depth.
    assign back_sum  = {1'b0, r_front} + (PTR_BITS + 1)'(r_count);
    assign back_wrap = (back_sum >= DEPTH_WIDE) ? back_sum - DEPTH_WIDE : back_sum;

    // Slot address: current front for a pop, new front or back slot for a push.
    always_comb begin
        if (i_sel_front) begin
            o_ring_addr = r_front;
        end else if (i_cmd.ins_front) begin
            o_ring_addr = front_dec;
        end else begin
            o_ring_addr = back_wrap[PTR_BITS-1:0];
        end
    end

    // Next pointer, count and sequence values.
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_seq   = r_seq;
        if (i_cmd.ins_front) begin
            n_front = front_dec;
            n_count = r_count + 1'b1;
        end else if (i_cmd.ins_back) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop) begin
            n_front = front_inc;
            n_count = r_count - 1'b1;
        end
        if (i_cmd.advance) begin
            n_seq = r_seq + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_seq   <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_seq   <= n_seq;
        end
    end

    assign o_occ.empty = (r_count == '0);
    assign o_occ.full  = (r_count == DEPTH_CNT);
    assign o_stamp     = r_seq;

endmodule
